[hw/rtl/hamming_12_8_stream_decoder_top_macros.svh]
// assertion macros for the hamming 12/8 stream decoder
`ifndef HAMMING_12_8_STREAM_DECODER_TOP_MACROS_SVH
`define HAMMING_12_8_STREAM_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define HSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hsd_pkg.sv]
// shared types and decode function for the hamming 12/8 stream decoder
`default_nettype none
package hsd_pkg;

  localparam int unsigned WORD_W  = 24;
  localparam int unsigned CW_W    = 12;
  localparam int unsigned BYTE_W  = 8;

  typedef logic [WORD_W-1:0] group_word_t;

  typedef struct packed {
    logic        valid;
    group_word_t word;
  } hsd_push_t;

  typedef struct packed {
    logic        valid;
    group_word_t word;
  } hsd_head_t;

  function automatic logic [BYTE_W-1:0] hsd_decode(input logic [CW_W-1:0] cw_in);
    logic [CW_W-1:0]   cw;
    logic [3:0]        syn;
    logic [BYTE_W-1:0] data;
    cw  = cw_in;
    syn = '0;
    for (int p = 1; p <= 12; p++) begin
      for (int c = 0; c < 4; c++) begin
        if (p[c]) begin
          syn[c] = syn[c] ^ cw[12-p];
        end
      end
    end
    if (syn inside {[4'd1:4'd12]}) begin
      cw = cw ^ (12'b1 << (4'd12 - syn));
    end
    data = {cw[9], cw[7], cw[6], cw[5], cw[3], cw[2], cw[1], cw[0]};
    return data;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/hsd_front.sv]
// front end: gathers three bytes into one group word
`default_nettype none
module hsd_front
  import hsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        q_full,
  output hsd_push_t        push
);

  logic [1:0]  count_r, count_nxt;
  logic [15:0] held_r, held_nxt;
  logic        in_fire;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    count_nxt  = count_r;
    held_nxt   = held_r;
    push.valid = 1'b0;
    push.word  = {held_r, in_byte};
    if (in_fire) begin
      case (count_r)
        2'd1: begin
          held_nxt  = {held_r[15:8], in_byte};
          count_nxt = 2'd2;
        end
        2'd2: begin
          push.valid = 1'b1;
          count_nxt  = 2'd0;
        end
        default: begin
          held_nxt  = {in_byte, held_r[7:0]};
          count_nxt = 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/hsd_queue.sv]
// two-entry queue of group words between front and back
`default_nettype none
module hsd_queue
  import hsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire hsd_push_t push,
  output logic           full,
  output hsd_head_t      head,
  input  wire logic      pop
);

`include "hamming_12_8_stream_decoder_top_macros.svh"

  group_word_t slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head.valid = (cnt_r != 2'd0);
  assign head.word  = slot_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.word;
    end
  end

  `HSD_ASSERT_NOW(a_no_push_when_full, push.valid, !full, "group pushed into full queue")
  `HSD_ASSERT_NOW(a_no_pop_when_empty, pop, head.valid, "pop from empty queue")
  `HSD_ASSERT_NOW(a_count_in_range, 1'b1, cnt_r != 2'd3, "queue count out of range")

endmodule
`default_nettype wire

[hw/rtl/hsd_back.sv]
// back end: corrects and emits the two data bytes of each group word
`default_nettype none
module hsd_back
  import hsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire hsd_head_t  head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

`include "hamming_12_8_stream_decoder_top_macros.svh"

  logic       phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       adv;
  logic       out_fire;

  assign adv       = !valid_r || !out_stall;
  assign out_fire  = valid_r && !out_stall;
  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (adv) begin
      valid_nxt = head.valid;
      if (head.valid) begin
        byte_nxt  = phase_r ? hsd_decode(head.word[11:0]) : hsd_decode(head.word[23:12]);
        last_nxt  = phase_r;
        phase_nxt = !phase_r;
        pop       = phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  `HSD_ASSERT_NOW(a_phase_has_word, phase_r, head.valid, "second half pending without a word")
  `HSD_ASSERT_NEXT(a_second_follows, out_fire && !last_r, valid_r && last_r,
    "second byte of group not ready after first")
  `HSD_ASSERT_NEXT(a_pop_resets_phase, pop, !phase_r, "phase not cleared after pop")

endmodule
`default_nettype wire

[hw/rtl/hamming_12_8_stream_decoder_top.sv]
// top level of the hamming 12/8 stream decoder
`default_nettype none
// Takes one raw byte per cycle while in_stall is low; every third byte completes
// a 24-bit group that holds two 12-bit codewords, each single-error corrected
// and emitted as one data byte (the second with out_last set). Sustained input
// rate is one byte per cycle while the queue has room; the output register emits
// at most one byte per cycle, so two bytes per group leave ample slack. The first
// data byte of a group goes through a queue slot and the output register; the
// second follows in the cycle after the first is taken. A two-entry group queue
// between gather and decode lets the input keep running while the output is
// stalled, until that queue fills. Syndromes 13 to 15 leave the codeword
// uncorrected; a partial trailing group produces nothing.
module hamming_12_8_stream_decoder_top
  import hsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  hsd_push_t push;
  hsd_head_t head;
  logic      q_full;
  logic      pop;

  hsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push)
  );

  hsd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  hsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

[dv/hamming_12_8_stream_decoder_top_test.sv]
// self-checking testbench for the hamming 12/8 stream decoder top level
`timescale 1ns / 1ps
module hamming_12_8_stream_decoder_top_test;
  import hsd_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_WAIT = 20;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } dec_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_stall = 1'b0;
  wire               in_stall;
  wire               out_valid;
  wire [BYTE_W-1:0]  out_byte;
  wire               out_last;

  logic [BYTE_W-1:0] raw_q[$];
  dec_word_t         decoded_q[$];
  logic              in_fire = 1'b0;
  logic [1:0]        grp_cnt = 2'd0;
  logic [15:0]       grp_held;
  int                cycle_cnt = 0;
  int                mismatches = 0;
  bit                quiet_in = 1'b0;
  bit                quiet_out = 1'b0;
  int                in_gap = 0;
  int                out_gap = 0;
  int                hold_left = 0;
  int                long_hold_req = 0;
  int                long_hold_seen = 0;

  hamming_12_8_stream_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // check bits of positions 8, 4, 2 and 1
  function automatic logic [3:0] syndrome_of(input logic [CW_W-1:0] cw);
    return {^(cw & 12'h01F), ^(cw & 12'h1E1), ^(cw & 12'h666), ^(cw & 12'hAAA)};
  endfunction

  function automatic logic [CW_W-1:0] flip(input logic [CW_W-1:0] cw, input int pos);
    return cw ^ (12'b1 << (12 - pos));
  endfunction

  function automatic logic [BYTE_W-1:0] decode_cw(input logic [CW_W-1:0] cw_in);
    logic [CW_W-1:0] cw;
    logic [3:0]      syn;
    cw  = cw_in;
    syn = syndrome_of(cw);
    if (syn >= 4'd1 && syn <= 4'd12) begin
      cw = flip(cw, int'(syn));
    end
    return {cw[9], cw[7], cw[6], cw[5], cw[3], cw[2], cw[1], cw[0]};
  endfunction

  function automatic logic [CW_W-1:0] encode(input logic [BYTE_W-1:0] d);
    logic [CW_W-1:0] cw;
    logic [3:0]      syn;
    cw = {2'b00, d[7], 1'b0, d[6], d[5], d[4], 1'b0, d[3], d[2], d[1], d[0]};
    syn = syndrome_of(cw);
    cw[11] = syn[0];
    cw[10] = syn[1];
    cw[8]  = syn[2];
    cw[4]  = syn[3];
    return cw;
  endfunction

  function automatic logic [CW_W-1:0] rand_cw();
    logic [BYTE_W-1:0] d;
    int                r;
    int                pa;
    int                pb;
    d  = BYTE_W'($urandom);
    r  = $urandom_range(0, 99);
    pa = $urandom_range(1, 12);
    pb = $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) begin
      d = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
    end
    if (r < 20) begin
      return encode(d);
    end
    if (r < 75) begin
      return flip(encode(d), pa);
    end
    if (r < 90) begin
      return flip(flip(encode(d), pa), pb);
    end
    return CW_W'($urandom);
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic predict_decode(input logic [BYTE_W-1:0] b);
    logic [23:0] word;
    if (grp_cnt == 2'd1) begin
      grp_held[7:0] = b;
      grp_cnt = 2'd2;
    end else if (grp_cnt == 2'd2) begin
      word = {grp_held, b};
      decoded_q.push_back('{data: decode_cw(word[23:12]), last: 1'b0});
      decoded_q.push_back('{data: decode_cw(word[11:0]), last: 1'b1});
      grp_cnt = 2'd0;
    end else begin
      grp_held = {b, 8'h00};
      grp_cnt = 2'd1;
    end
  endtask

  task automatic push_group(input logic [CW_W-1:0] first_cw, input logic [CW_W-1:0] second_cw);
    logic [23:0] w;
    w = {first_cw, second_cw};
    raw_q.push_back(w[23:16]);
    raw_q.push_back(w[15:8]);
    raw_q.push_back(w[7:0]);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (raw_q.size() != 0 || in_valid || decoded_q.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (in_valid && !in_fire) begin
      // stalled, hold the byte
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (raw_q.size() > 0) begin
      in_valid <= 1'b1;
      in_byte  <= raw_q.pop_front();
      in_gap   <= pick_gap(quiet_in);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_decode(in_byte);
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
      hold_left <= 0;
    end else if (long_hold_seen != long_hold_req) begin
      long_hold_seen <= long_hold_req;
      hold_left      <= LONG_HOLD;
      out_stall      <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_gap   <= pick_gap(quiet_out);
    end
  end

  always @(posedge clk) begin
    dec_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected word", int'(out_byte), 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data) begin
          report_mismatch("out_byte", int'(out_byte), int'(want.data));
        end
        if (out_last !== want.last) begin
          report_mismatch("out_last", int'(out_last), int'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    @(posedge clk);
    while (cycle_cnt < RUN_LIMIT) @(posedge clk);
    $display("FAIL hamming_12_8_stream_decoder_top");
    $finish;
  end

  initial begin
    logic [23:0] word;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    push_group(encode(8'h00), encode(8'hFF));
    for (int p = 1; p <= 12; p += 2) begin
      push_group(flip(encode(BYTE_W'($urandom)), p), flip(encode(BYTE_W'($urandom)), p + 1));
    end
    // double errors that land on syndromes past the codeword length
    push_group(flip(flip(encode(8'h3C), 1), 12), flip(flip(encode(8'hC3), 3), 12));
    word = {flip(flip(encode(8'h5A), 2), 12), 12'hFFF};
    raw_q.push_back(word[23:16]);
    raw_q.push_back(word[15:8]);
    // pause in the middle of a group
    wait_drained();
    raw_q.push_back(word[7:0]);
    wait_drained();

    // receiver holds off while the sender keeps going
    quiet_in = 1'b1;
    long_hold_req++;
    repeat (60) push_group(rand_cw(), rand_cw());
    wait_drained();
    quiet_in = 1'b0;

    for (int chunk = 0; chunk < 12; chunk++) begin
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      repeat (40) push_group(rand_cw(), rand_cw());
      if (chunk % 4 == 3) begin
        wait_drained();
      end
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;

    // trailing partial group
    raw_q.push_back(BYTE_W'($urandom));
    raw_q.push_back(BYTE_W'($urandom));
    wait_drained();
    repeat (TAIL_WAIT) @(negedge clk);

    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("PASS hamming_12_8_stream_decoder_top");
    end else begin
      $display("FAIL hamming_12_8_stream_decoder_top");
    end
    $finish;
  end

endmodule
